FILE: sv/plru_pkg.sv
// Shared constants, codes and control types for the pinned LRU replacement core.
`timescale 1ns / 1ps
package plru_pkg;

  localparam int FRAMES   = 64;
  localparam int PIN_BITS = 8;
  localparam int PAGE_W   = 6;
  localparam int IDX_W    = $clog2(FRAMES);
  // link values span the frames plus the sentinel
  localparam int LINK_W   = $clog2(FRAMES + 1);

  localparam logic [LINK_W-1:0]   SENT    = LINK_W'(FRAMES);
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
  localparam logic [PIN_BITS-1:0] PIN_ONE = PIN_BITS'(1);

  localparam logic [1:0] OP_HIT   = 2'd0;
  localparam logic [1:0] OP_PIN   = 2'd1;
  localparam logic [1:0] OP_STALE = 2'd2;
  localparam logic [1:0] OP_UNPIN = 2'd3;

  localparam logic [2:0] FAULT_NONE           = 3'd0;
  localparam logic [2:0] FAULT_UNDERFLOW      = 3'd1;
  localparam logic [2:0] FAULT_OVERFLOW       = 3'd2;
  localparam logic [2:0] FAULT_PINNED_HEAD    = 3'd3;
  localparam logic [2:0] FAULT_UNLISTED_CLEAN = 3'd4;

  localparam logic CFG_SEQ_WRITES = 1'b0;
  localparam logic CFG_STRESS     = 1'b1;

  typedef struct packed {
    logic accept;
    logic exec;
    logic app1;
    logic app2;
    logic emit;
  } plru_cmd_t;

  typedef struct packed {
    logic need_append;
    logic out_free;
  } plru_stat_t;

endpackage

FILE: sv/plru_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module plru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/plru_ctrl.sv
// Sequencer for the replacement core: accept, execute, optional append, emit.
`timescale 1ns / 1ps
module plru_ctrl import plru_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  plru_stat_t stat,
  output plru_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_APP1 = 3'd2;
  localparam logic [2:0] S_APP2 = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.need_append ? S_APP1 : S_EMIT;
      end
      S_APP1: begin
        cmd.app1   = 1'b1;
        state_next = S_APP2;
      end
      S_APP2: begin
        cmd.app2   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/plru_dp.sv
// Datapath: link and pin-count memories, sentinel head/tail, listed flags, result register.
`timescale 1ns / 1ps
module plru_dp import plru_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  plru_cmd_t         cmd,
  output plru_stat_t        stat,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic              cfg_data,
  input  logic [1:0]        opcode,
  input  logic [PAGE_W-1:0] page_index,
  input  logic              page_dirty,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PAGE_W-1:0] result_page,
  output logic              result_valid,
  output logic [PAGE_W-1:0] stale_page,
  output logic              stale_valid,
  output logic [2:0]        fault
);

  logic seq_writes;
  logic stress;

  logic [1:0]        op;
  logic              dirty;
  logic              in_pool;
  logic [LINK_W-1:0] tgt;
  logic [LINK_W-1:0] tgt_in;
  logic [LINK_W-1:0] head;
  logic [LINK_W-1:0] tail;
  logic [FRAMES-1:0] listed;
  logic [FRAMES-1:0] pc_ok;   // pin count entry written since reset

  logic [LINK_W-1:0] rpage;
  logic              rvalid;
  logic [2:0]        rfault;

  logic [LINK_W-1:0]   next_rdata;
  logic [LINK_W-1:0]   prev_rdata;
  logic [PIN_BITS-1:0] pc_rdata;

  logic                next_we;
  logic [IDX_W-1:0]    next_waddr;
  logic [LINK_W-1:0]   next_wdata;
  logic                prev_we;
  logic [IDX_W-1:0]    prev_waddr;
  logic [LINK_W-1:0]   prev_wdata;

  logic [IDX_W-1:0]    tgt_idx;
  logic                tgt_listed;
  logic [PIN_BITS-1:0] pcv;
  logic                keep_out;
  logic                x_unlink;
  logic                x_append;
  logic                x_pc_we;
  logic [PIN_BITS-1:0] x_pc_val;
  logic                x_res;
  logic [2:0]          x_fault;

  assign tgt_in     = (opcode == OP_STALE) ? head : LINK_W'(page_index);
  assign tgt_idx    = tgt[IDX_W-1:0];
  assign tgt_listed = listed[tgt_idx];
  assign pcv        = pc_ok[tgt_idx] ? pc_rdata : PIN_ONE;
  assign keep_out   = seq_writes && !stress && dirty;

  // decision for the beat in flight; memory read data is from the accept address
  always_comb begin
    x_unlink = 1'b0;
    x_append = 1'b0;
    x_pc_we  = 1'b0;
    x_pc_val = PIN_ONE;
    x_res    = 1'b0;
    x_fault  = FAULT_NONE;
    case (op)
      OP_STALE: begin
        if (head != SENT) begin
          if (pcv != '0) begin
            x_fault = FAULT_PINNED_HEAD;
          end else begin
            x_unlink = 1'b1;
            x_pc_we  = 1'b1;
            x_res    = 1'b1;
          end
        end
      end
      OP_HIT: begin
        if (in_pool && tgt_listed) begin
          x_unlink = 1'b1;
          x_append = 1'b1;
        end
      end
      OP_PIN: begin
        if (in_pool) begin
          if (pcv == PIN_MAX) begin
            x_fault = FAULT_OVERFLOW;
          end else if (pcv == '0) begin
            if (tgt_listed) begin
              x_unlink = 1'b1;
              x_pc_we  = 1'b1;
              x_res    = 1'b1;
            end else if (dirty) begin
              x_pc_we = 1'b1;
              x_res   = 1'b1;
            end else begin
              x_fault = FAULT_UNLISTED_CLEAN;
            end
          end else begin
            x_pc_we  = 1'b1;
            x_pc_val = pcv + PIN_ONE;
          end
        end
      end
      OP_UNPIN: begin
        if (in_pool) begin
          if (pcv == '0) begin
            x_fault = FAULT_UNDERFLOW;
          end else begin
            x_pc_we  = 1'b1;
            x_pc_val = pcv - PIN_ONE;
            x_append = (pcv == PIN_ONE) && !keep_out && !tgt_listed;
          end
        end
      end
      default: begin
        x_fault = FAULT_NONE;
      end
    endcase
  end

  assign stat.need_append = x_append;
  assign stat.out_free    = !out_valid || out_ready;

  // link memory write ports: unlink in exec, append in app1 and app2
  always_comb begin
    next_we    = (cmd.exec && x_unlink && (prev_rdata != SENT)) || cmd.app1
                 || (cmd.app2 && (tail != SENT));
    next_waddr = tail[IDX_W-1:0];
    next_wdata = tgt;
    if (cmd.exec) begin
      next_waddr = prev_rdata[IDX_W-1:0];
      next_wdata = next_rdata;
    end else if (cmd.app1) begin
      next_waddr = tgt_idx;
      next_wdata = SENT;
    end
    prev_we    = (cmd.exec && x_unlink && (next_rdata != SENT)) || cmd.app1;
    prev_waddr = cmd.exec ? next_rdata[IDX_W-1:0] : tgt_idx;
    prev_wdata = cmd.exec ? prev_rdata : tail;
  end

  plru_ram #(.WIDTH(LINK_W), .DEPTH(FRAMES)) u_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (tgt_in[IDX_W-1:0]),
    .rdata (next_rdata)
  );

  plru_ram #(.WIDTH(LINK_W), .DEPTH(FRAMES)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (tgt_in[IDX_W-1:0]),
    .rdata (prev_rdata)
  );

  plru_ram #(.WIDTH(PIN_BITS), .DEPTH(FRAMES)) u_pin (
    .clk   (clk),
    .we    (cmd.exec && x_pc_we),
    .waddr (tgt_idx),
    .wdata (x_pc_val),
    .raddr (tgt_in[IDX_W-1:0]),
    .rdata (pc_rdata)
  );

  // beat capture, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op      <= opcode;
      dirty   <= page_dirty;
      in_pool <= (int'(page_index) < FRAMES);
      tgt     <= tgt_in;
    end
    if (cmd.exec) begin
      rpage  <= x_res ? tgt : '0;
      rvalid <= x_res;
      rfault <= x_fault;
    end
    if (cmd.emit) begin
      result_page  <= PAGE_W'(rpage);
      result_valid <= rvalid;
      fault        <= rfault;
      stale_valid  <= (head != SENT);
      stale_page   <= (head != SENT) ? PAGE_W'(head) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_writes <= 1'b0;
      stress     <= 1'b0;
      head       <= SENT;
      tail       <= SENT;
      listed     <= '0;
      pc_ok      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEQ_WRITES: seq_writes <= cfg_data;
          CFG_STRESS:     stress     <= cfg_data;
          default:        stress     <= stress;
        endcase
      end
      if (cmd.exec) begin
        if (x_unlink) begin
          listed[tgt_idx] <= 1'b0;
          if (prev_rdata == SENT) begin
            head <= next_rdata;
          end
          if (next_rdata == SENT) begin
            tail <= prev_rdata;
          end
        end
        if (x_pc_we) begin
          pc_ok[tgt_idx] <= 1'b1;
        end
      end
      if (cmd.app2) begin
        listed[tgt_idx] <= 1'b1;
        tail            <= tgt;
        if (tail == SENT) begin
          head <= tgt;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/pinned_lru_replacement_core.sv
// Top level of the pinned LRU replacement core.
`timescale 1ns / 1ps
// One operation is taken at a time. An accepted beat goes to execute, where
// the link and pin-count memories give the named frame's neighbors and count
// and the result register is loaded, then to emit. A hit on a listed frame,
// and an unpin that lists its frame, pass through the append states APP1 and
// APP2 before emit, since appending writes the next-link memory twice through
// its single write port. A result that waits on out_ready holds back the next
// accept only once the following operation is done. The sentinel head and
// tail live in registers, so the link memories need no clearing after reset;
// pin counts read as one until first written.
module pinned_lru_replacement_core import plru_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [PAGE_W-1:0] page_index,
  input  logic              page_dirty,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PAGE_W-1:0] result_page,
  output logic              result_valid,
  output logic [PAGE_W-1:0] stale_page,
  output logic              stale_valid,
  output logic [2:0]        fault
);

  plru_cmd_t  cmd;
  plru_stat_t stat;

  plru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plru_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (opcode),
    .page_index   (page_index),
    .page_dirty   (page_dirty),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_page  (result_page),
    .result_valid (result_valid),
    .stale_page   (stale_page),
    .stale_valid  (stale_valid),
    .fault        (fault)
  );

endmodule

FILE: sv/plru_checker.sv
// Port-level checks for the pinned LRU replacement core, bound to the top level.
`timescale 1ns / 1ps
module plru_checker import plru_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PAGE_W-1:0] result_page,
  input logic              result_valid,
  input logic [PAGE_W-1:0] stale_page,
  input logic              stale_valid,
  input logic [2:0]        fault
);

  // one operation at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted back to back");

  // a faulting beat never returns a frame
  a_fault_no_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (fault != FAULT_NONE)) |-> !result_valid)
    else $error("frame returned with fault");

  // null results and an empty list read as frame zero
  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((result_valid || (result_page == '0))
                   && (stale_valid || (stale_page == '0))))
    else $error("null field carries a frame");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result_page)
                                   && $stable(fault) && $stable(stale_page)))
    else $error("result beat changed while stalled");

endmodule

bind pinned_lru_replacement_core plru_checker u_plru_checker (.*);

FILE: test/testbench.sv
// Self-checking testbench for the pinned LRU replacement core with its own list predictor.
`timescale 1ns / 1ps
module testbench;
  import plru_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_OPS   = 270;

  typedef struct packed {
    logic [PAGE_W-1:0] res_page;
    logic              res_valid;
    logic [PAGE_W-1:0] stale_page;
    logic              stale_valid;
    logic [2:0]        fault;
  } lru_result_t;

  // Tracks the LRU list and pin counts; queues the result each accepted op should give.
  class frame_order_tracker;
    logic [LINK_W-1:0]   nxt[FRAMES+1];
    logic [LINK_W-1:0]   prv[FRAMES+1];
    bit                  on_list[FRAMES];
    logic [PIN_BITS-1:0] pins[FRAMES];
    bit                  seq_mode;
    bit                  stress_mode;
    lru_result_t         due_results[$];
    int                  errors;

    function new();
      for (int i = 0; i <= FRAMES; i++) begin
        nxt[i] = SENT;
        prv[i] = SENT;
      end
      for (int i = 0; i < FRAMES; i++) begin
        on_list[i] = 1'b0;
        pins[i] = PIN_ONE;
      end
      seq_mode = 1'b0;
      stress_mode = 1'b0;
      errors = 0;
    endfunction

    function void unlink(int f);
      logic [LINK_W-1:0] a;
      logic [LINK_W-1:0] b;
      a = prv[f];
      b = nxt[f];
      nxt[a] = b;
      prv[b] = a;
      on_list[f] = 1'b0;
    endfunction

    function void append(int f);
      logic [LINK_W-1:0] t;
      t = prv[SENT];
      nxt[f] = SENT;
      prv[f] = t;
      nxt[t] = LINK_W'(f);
      prv[SENT] = LINK_W'(f);
      on_list[f] = 1'b1;
    endfunction

    function void apply_op(logic [1:0] op, logic [PAGE_W-1:0] page, logic dirty);
      lru_result_t       r;
      logic [LINK_W-1:0] h;
      logic              keep_out;
      int                f;
      r = '0;
      f = int'(page);
      case (op)
        OP_STALE: begin
          h = nxt[SENT];
          if (h != SENT) begin
            if (pins[h] != 0) begin
              r.fault = FAULT_PINNED_HEAD;
            end else begin
              unlink(h);
              pins[h] = PIN_ONE;
              r.res_page = h[PAGE_W-1:0];
              r.res_valid = 1'b1;
            end
          end
        end
        OP_HIT: begin
          if (on_list[f]) begin
            unlink(f);
            append(f);
          end
        end
        OP_PIN: begin
          if (pins[f] == PIN_MAX) begin
            r.fault = FAULT_OVERFLOW;
          end else if (pins[f] == 0) begin
            if (on_list[f]) begin
              unlink(f);
              pins[f] = PIN_ONE;
              r.res_page = page;
              r.res_valid = 1'b1;
            end else if (dirty) begin
              // frame was held out of the list, so a dirty pin may claim it
              pins[f] = PIN_ONE;
              r.res_page = page;
              r.res_valid = 1'b1;
            end else begin
              r.fault = FAULT_UNLISTED_CLEAN;
            end
          end else begin
            pins[f] = pins[f] + 1'b1;
          end
        end
        default: begin
          if (pins[f] == 0) begin
            r.fault = FAULT_UNDERFLOW;
          end else begin
            pins[f] = pins[f] - 1'b1;
            keep_out = seq_mode && !stress_mode && dirty;
            if (pins[f] == 0 && !keep_out && !on_list[f]) append(f);
          end
        end
      endcase
      h = nxt[SENT];
      if (h != SENT) begin
        r.stale_page = h[PAGE_W-1:0];
        r.stale_valid = 1'b1;
      end
      due_results.push_back(r);
    endfunction

    function void check_result(lru_result_t got);
      lru_result_t want;
      if (due_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.res_page !== want.res_page) begin
        $error("result_page: expected %0d, got %0d", want.res_page, got.res_page);
        errors++;
      end
      if (got.res_valid !== want.res_valid) begin
        $error("result_valid: expected %0d, got %0d", want.res_valid, got.res_valid);
        errors++;
      end
      if (got.stale_page !== want.stale_page) begin
        $error("stale_page: expected %0d, got %0d", want.stale_page, got.stale_page);
        errors++;
      end
      if (got.stale_valid !== want.stale_valid) begin
        $error("stale_valid: expected %0d, got %0d", want.stale_valid, got.stale_valid);
        errors++;
      end
      if (got.fault !== want.fault) begin
        $error("fault: expected %0d, got %0d", want.fault, got.fault);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic              cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        opcode;
  logic [PAGE_W-1:0] page_index;
  logic              page_dirty;
  logic              out_valid;
  logic              out_ready;
  logic [PAGE_W-1:0] result_page;
  logic              result_valid;
  logic [PAGE_W-1:0] stale_page;
  logic              stale_valid;
  logic [2:0]        fault;

  frame_order_tracker book = new();
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_req;
  int quiet_cycles;

  pinned_lru_replacement_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .page_index(page_index), .page_dirty(page_dirty),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_page(result_page), .result_valid(result_valid),
    .stale_page(stale_page), .stale_valid(stale_valid), .fault(fault)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus an occasional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      book.check_result(lru_result_t'{result_page, result_valid, stale_page,
                                      stale_valid, fault});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_beat(logic [1:0] op, logic [PAGE_W-1:0] page, logic dirty);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    page_index <= page;
    page_dirty <= dirty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.apply_op(op, page, dirty);
  endtask

  // drain all results, then wait with no input driven
  task automatic settle();
    in_valid <= 1'b0;
    while (book.due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_modes(logic seq, logic stress);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SEQ_WRITES;
    cfg_data <= seq;
    @(posedge clk);
    book.seq_mode = seq;
    cfg_index <= CFG_STRESS;
    cfg_data <= stress;
    @(posedge clk);
    book.stress_mode = stress;
    cfg_we <= 1'b0;
  endtask

  // unpins and hits aimed at frames whose state makes them interesting, some pure noise
  task automatic random_op();
    int         pick;
    int         p;
    int         tries;
    logic [1:0] op;
    logic       d;
    pick = $urandom_range(0, 99);
    p = $urandom_range(0, FRAMES - 1);
    d = 1'($urandom_range(0, 1));
    tries = 0;
    if (pick < 25) begin
      op = OP_UNPIN;
      while (tries < 8 && book.pins[p] == 0) begin
        p = $urandom_range(0, FRAMES - 1);
        tries++;
      end
    end else if (pick < 45) begin
      op = OP_HIT;
      while (tries < 8 && !book.on_list[p]) begin
        p = $urandom_range(0, FRAMES - 1);
        tries++;
      end
    end else if (pick < 60) begin
      op = OP_PIN;
    end else if (pick < 75) begin
      op = OP_STALE;
    end else begin
      op = 2'($urandom_range(0, 3));
    end
    send_beat(op, PAGE_W'(p), d);
  endtask

  // drive one frame's pin count to the ceiling, try once more past it, and back to zero
  task automatic saturate_frame(int f);
    send_beat(OP_PIN, PAGE_W'(f), 1'b1);
    while (book.pins[f] != PIN_MAX)
      send_beat(OP_PIN, PAGE_W'(f), 1'($urandom_range(0, 1)));
    send_beat(OP_PIN, PAGE_W'(f), 1'($urandom_range(0, 1)));
    while (book.pins[f] != 0)
      send_beat(OP_UNPIN, PAGE_W'(f), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [1:0] modes[4];
    modes = '{2'b00, 2'b01, 2'b10, 2'b11};
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SEQ_WRITES;
    cfg_data <= 1'b0;
    in_valid <= 1'b0;
    opcode <= OP_HIT;
    page_index <= '0;
    page_dirty <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, underflow, reordering, pin paths
    send_beat(OP_STALE, 6'd0, 1'b0);
    send_beat(OP_HIT, 6'd0, 1'b0);
    send_beat(OP_UNPIN, 6'd0, 1'b0);
    send_beat(OP_UNPIN, 6'd0, 1'b1);
    send_beat(OP_UNPIN, 6'd63, 1'b1);
    send_beat(OP_HIT, 6'd0, 1'b0);
    send_beat(OP_PIN, 6'd63, 1'b0);
    send_beat(OP_STALE, 6'd0, 1'b0);
    send_beat(OP_PIN, 6'd0, 1'b1);
    send_beat(OP_UNPIN, 6'd0, 1'b0);
    send_beat(OP_UNPIN, 6'd0, 1'b1);
    send_beat(OP_STALE, 6'd63, 1'b1);
    settle();
    // dirty frames held out of the list
    set_modes(1'b1, 1'b0);
    send_beat(OP_UNPIN, 6'd5, 1'b1);
    send_beat(OP_PIN, 6'd5, 1'b0);
    send_beat(OP_PIN, 6'd5, 1'b1);
    send_beat(OP_UNPIN, 6'd5, 1'b0);
    send_beat(OP_UNPIN, 6'd6, 1'b1);
    settle();
    set_modes(1'b1, 1'b1);
    send_beat(OP_UNPIN, 6'd7, 1'b1);
    send_beat(OP_HIT, 6'd5, 1'b0);
    send_beat(OP_PIN, 6'd6, 1'b1);
    send_beat(OP_HIT, 6'd63, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      set_modes(modes[ph][1], modes[ph][0]);
      case (ph)
        0: begin
          tx_idle_pct = 16;
          rx_idle_pct = 77;
        end
        1: begin
          tx_idle_pct = 77;
          rx_idle_pct = 16;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (ph == 2) hold_req = HOLD_CYCLES;
      if (ph == 3) saturate_frame($urandom_range(0, FRAMES - 1));
      repeat (PHASE_OPS) random_op();
    end

    in_valid <= 1'b0;
    while (book.due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.errors == 0 && book.due_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
sv/plru_pkg.sv
sv/plru_ram.sv
sv/plru_ctrl.sv
sv/plru_dp.sv
sv/pinned_lru_replacement_core.sv
sv/plru_checker.sv
test/testbench.sv
